@@ rtl/sobel_pkg.sv @@
// Shared constants and types for the Sobel gradient magnitude core.
// No dependencies; used by every module under rtl/.
package sobel_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 13;
  localparam int GRAD_BITS  = 11;
  localparam int MAG_BITS   = 15;
  localparam int SQ_BITS    = 30;
  localparam int SQRT_STEPS = 15;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [ROW_BITS-1:0]         row;
    logic [COL_BITS-1:0]         col;
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
  } grad_item_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_ROOT, ST_DONE} root_state_t;
endpackage

@@ rtl/sobel_gradient_magnitude_core.sv @@
// Top level of the Sobel 3x3 gradient magnitude core.
// Depends on sobel_pkg, sobel_front, sobel_queue and sobel_back.
//
// channel  dir  tdata fields (low bit up)                         notes
// in_      in   pixel[7:0]                                        raster order
// out_     out  out_row[11:0] out_col[21:12] grad_x[32:22]
//               grad_y[43:33] magnitude[58:44], pad to 64
// cfg_     in   index 0 frame_width, 1 frame_height               restarts frame
//
// Each interior result passes through the shared square-root unit,
// one root bit per cycle; that unit sets the sustained rate.
// Pixels stream in at one per cycle until the four-entry queue fills.
// Reset is synchronous, active low; line stores hold garbage until written.
// Either side may stall at any time without loss.
module sobel_gradient_magnitude_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_row, out_col, grad_x, grad_y, magnitude
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic fv, fr, qv, qr;
  sobel_pkg::grad_item_t fi, qi, ri;
  logic [sobel_pkg::MAG_BITS-1:0] mag;

  assign cfg_ready = 1'b1;

  sobel_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .pix_valid(in_tvalid), .pix_ready(in_tready), .pix(in_tdata),
    .item_valid(fv), .item_ready(fr), .item(fi)
  );
  sobel_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_item(fi),
    .rd_valid(qv), .rd_ready(qr), .rd_item(qi)
  );
  sobel_back u_back (
    .clk, .rst_n, .item_valid(qv), .item_ready(qr), .item(qi),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_item(ri), .res_mag(mag)
  );

  assign out_tdata = {5'b0, mag, ri.gy, ri.gx, ri.col, ri.row};
endmodule

@@ rtl/sobel_front.sv @@
// Front end: frame position, line stores, 3x3 window and Sobel gradients.
// Depends on sobel_pkg. Emits one grad_item_t per interior pixel.
module sobel_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [sobel_pkg::PIXEL_BITS-1:0] pix,
  output logic                          item_valid,
  input  logic                          item_ready,
  output sobel_pkg::grad_item_t         item
);
  localparam int PB = sobel_pkg::PIXEL_BITS;
  localparam int CB = sobel_pkg::COL_BITS;
  localparam int RB = sobel_pkg::ROW_BITS;

  logic [sobel_pkg::FW_BITS-1:0] fw_r;
  logic [sobel_pkg::FH_BITS-1:0] fh_r;
  logic [CB:0] w_eff;
  logic [RB:0] h_eff;
  logic [CB-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [PB-1:0] up_mem [sobel_pkg::MAX_WIDTH];
  logic [PB-1:0] mid_mem [sobel_pkg::MAX_WIDTH];
  logic [PB-1:0] up_rd, mid_rd;
  logic [PB-1:0] pix_s1;
  logic [CB-1:0] col_s1;
  logic [RB-1:0] row_s1;
  logic          s1_r, s2_r, emit;
  logic [PB-1:0] win_r [3][3];
  logic [CB-1:0] col_s2;
  logic [RB-1:0] row_s2;
  logic          adv, cfg_wr;
  logic [PB+1:0] sxr, sxl, syb, syt;

  assign cfg_wr = cfg_valid && (cfg_index == {1'b0, sobel_pkg::CFG_FRAME_WIDTH} ||
                                cfg_index == {1'b0, sobel_pkg::CFG_FRAME_HEIGHT});
  assign adv = !item_valid || item_ready;
  assign pix_ready = adv;

  always_comb begin
    if (fw_r < 3) w_eff = (CB+1)'(3);
    else if (fw_r > sobel_pkg::FW_BITS'(sobel_pkg::MAX_WIDTH)) w_eff = (CB+1)'(sobel_pkg::MAX_WIDTH);
    else w_eff = (CB+1)'(fw_r);
    if (fh_r < 3) h_eff = (RB+1)'(3);
    else if (fh_r > sobel_pkg::FH_BITS'(sobel_pkg::MAX_HEIGHT)) h_eff = (RB+1)'(sobel_pkg::MAX_HEIGHT);
    else h_eff = (RB+1)'(fh_r);
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if ({1'b0, col_r} + 1'b1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_r} + 1'b1 >= h_eff) ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= sobel_pkg::FW_BITS'(640);
      fh_r <= sobel_pkg::FH_BITS'(480);
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index[0] == sobel_pkg::CFG_FRAME_WIDTH) fw_r <= cfg_data[sobel_pkg::FW_BITS-1:0];
      else fh_r <= cfg_data[sobel_pkg::FH_BITS-1:0];
      col_r <= '0;
      row_r <= '0;
    end else if (pix_valid && pix_ready) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      up_rd  <= up_mem[col_r];
      mid_rd <= mid_mem[col_r];
      up_mem[col_r]  <= mid_mem[col_r];
      mid_mem[col_r] <= pix;
      pix_s1 <= pix;
      col_s1 <= col_r;
      row_s1 <= row_r;
    end
  end

  // stage 1 holds the line-store reads, stage 2 shifts them into the window for the gradient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_r[r][c] <= '0;
    end else if (adv) begin
      s1_r <= pix_valid;
      s2_r <= s1_r && row_s1 >= 2 && col_s1 >= 2;
      if (s1_r) begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 2; c++) win_r[r][c] <= win_r[r][c+1];
        win_r[0][2] <= up_rd;
        win_r[1][2] <= mid_rd;
        win_r[2][2] <= pix_s1;
        col_s2 <= col_s1 - 1'b1;
        row_s2 <= row_s1 - 1'b1;
      end
    end
  end

  assign sxr = {2'b0, win_r[0][2]} + {1'b0, win_r[1][2], 1'b0} + {2'b0, win_r[2][2]};
  assign sxl = {2'b0, win_r[0][0]} + {1'b0, win_r[1][0], 1'b0} + {2'b0, win_r[2][0]};
  assign syb = {2'b0, win_r[2][0]} + {1'b0, win_r[2][1], 1'b0} + {2'b0, win_r[2][2]};
  assign syt = {2'b0, win_r[0][0]} + {1'b0, win_r[0][1], 1'b0} + {2'b0, win_r[0][2]};

  assign emit = s2_r;
  assign item_valid = emit;
  assign item.row = row_s2;
  assign item.col = col_s2;
  assign item.gx = sobel_pkg::GRAD_BITS'($signed({1'b0, sxr}) - $signed({1'b0, sxl}));
  assign item.gy = sobel_pkg::GRAD_BITS'($signed({1'b0, syb}) - $signed({1'b0, syt}));
endmodule

@@ rtl/sobel_queue.sv @@
// Short FIFO decoupling gradient front end from magnitude back end.
// Depends on sobel_pkg for grad_item_t and depth.
module sobel_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  sobel_pkg::grad_item_t wr_item,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output sobel_pkg::grad_item_t rd_item
);
  localparam int PW = sobel_pkg::QPTR_BITS;
  sobel_pkg::grad_item_t mem_r [sobel_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != (PW+1)'(sobel_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(sobel_pkg::QDEPTH)) else $error("queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wp_r == rp_r) else $error("queue pointers disagree");
endmodule

@@ rtl/sobel_back.sv @@
// Back end: squares gradients and runs a bit-serial integer square root.
// Depends on sobel_pkg. One result per item; a new item is taken only once the last result has left.
module sobel_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  sobel_pkg::grad_item_t item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sobel_pkg::grad_item_t res_item,
  output logic [sobel_pkg::MAG_BITS-1:0] res_mag
);
  localparam int SB = sobel_pkg::SQ_BITS;
  localparam int MB = sobel_pkg::MAG_BITS;
  sobel_pkg::root_state_t st_r, st_nxt;
  sobel_pkg::grad_item_t  it_r;
  logic [SB-1:0] rem_r;
  logic [MB-1:0] root_r;
  logic [3:0]    step_r;
  logic [9:0]    ax, ay;
  logic [SB+1:0] trial;
  logic [SB+1:0] rem_sh;
  logic [SB-1:0] rad_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sobel_pkg::ST_IDLE:   if (item_valid) st_nxt = sobel_pkg::ST_SQUARE;
      sobel_pkg::ST_SQUARE: st_nxt = sobel_pkg::ST_ROOT;
      sobel_pkg::ST_ROOT:   if (step_r == 4'd0) st_nxt = sobel_pkg::ST_DONE;
      sobel_pkg::ST_DONE:   if (res_ready) st_nxt = sobel_pkg::ST_IDLE;
      default:              st_nxt = sobel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = st_r == sobel_pkg::ST_IDLE;
    res_valid  = st_r == sobel_pkg::ST_DONE;
  end

  assign ax = it_r.gx[10] ? 10'(-it_r.gx) : it_r.gx[9:0];
  assign ay = it_r.gy[10] ? 10'(-it_r.gy) : it_r.gy[9:0];
  // restoring root: bring down two radicand bits per step
  assign rem_sh = {rem_r, 2'b00};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sobel_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      sobel_pkg::ST_IDLE: if (item_valid) it_r <= item;
      sobel_pkg::ST_SQUARE: begin
        rad_r  <= SB'({{11'b0, ax} * {11'b0, ax} + {11'b0, ay} * {11'b0, ay}, 8'b0});
        rem_r  <= '0;
        root_r <= '0;
        step_r <= 4'(sobel_pkg::SQRT_STEPS - 1);
      end
      sobel_pkg::ST_ROOT: begin
        if ({rem_sh[SB+1:2], rad_r[SB-1:SB-2]} >= trial) begin
          rem_r  <= SB'({rem_sh[SB+1:2], rad_r[SB-1:SB-2]} - trial);
          root_r <= {root_r[MB-2:0], 1'b1};
        end else begin
          rem_r  <= SB'({rem_sh[SB+1:2], rad_r[SB-1:SB-2]});
          root_r <= {root_r[MB-2:0], 1'b0};
        end
        rad_r  <= {rad_r[SB-3:0], 2'b00};
        step_r <= step_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign res_item = it_r;
  assign res_mag  = root_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_mag)) else $error("result dropped");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_ready |-> !res_valid) else $error("accept while busy");
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_mag <= MB'(23088)) else $error("magnitude out of range");
endmodule
